[rtl/csrb_pkg.sv]
// csrb_pkg: shared types and codes for the clipped sprite row blitter.
// Holds the per-item plan record passed from the decode stage to the control.
// No dependencies.
package csrb_pkg;

  localparam logic KIND_BLIT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // byte lanes of a big-endian framebuffer word
  localparam logic [1:0] LANE_LO   = 2'b01;
  localparam logic [1:0] LANE_HI   = 2'b10;
  localparam logic [1:0] LANE_BOTH = 2'b11;

  typedef struct packed {
    logic        is_read;
    logic        rd_ok;
    logic        drawn;
    logic        done;
    logic        erase;
    logic        u0_en;
    logic        u1_en;
    logic [1:0]  lane0;
    logic [1:0]  lane1;
    logic [15:0] val0;
    logic [15:0] val1;
  } csrb_plan_t;

endpackage

[rtl/csrb_fb_ram.sv]
// csrb_fb_ram: single-port framebuffer word memory with a registered read.
// Depends on nothing.
module csrb_fb_ram #(
  parameter int DEPTH = 16000,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/csrb_plan.sv]
// csrb_plan: registered decode of one beat into clipping flags, word addresses,
// shifted unit values and byte lanes. Depends on csrb_pkg.
module csrb_plan
  import csrb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 400,
  parameter int AW            = 14
) (
  input  logic               clk,
  input  logic               load,
  input  logic               kind,
  input  logic signed [10:0] sprite_x,
  input  logic signed [9:0]  sprite_y,
  input  logic [7:0]         row_index,
  input  logic [15:0]        row_bits,
  input  logic               wide,
  input  logic               erase,
  input  logic               last_row,
  input  logic [13:0]        read_address,
  output csrb_plan_t         plan_r,
  output logic [AW-1:0]      addr0_r,
  output logic [AW-1:0]      addr1_r
);

  localparam int ROW_WORDS = (SCREEN_WIDTH + 15) / 16;
  localparam int FB_WORDS  = ROW_WORDS * SCREEN_HEIGHT;

  function automatic logic [15:0] place(input logic [15:0] v, input logic [1:0] lane);
    logic [15:0] r;
    unique case (lane)
      LANE_LO: r = {8'h00, v[7:0]};
      LANE_HI: r = {v[7:0], 8'h00};
      default: r = v;
    endcase
    return r;
  endfunction

  logic signed [10:0] row;
  logic               row_ok;
  logic               x_ok;
  logic               neg;
  logic [3:0]         neg_sh;
  logic [3:0]         off;
  logic [4:0]         back;
  logic [15:0]        mask16;
  logic [15:0]        bits16;
  logic [15:0]        v_first;
  logic [15:0]        v_second;
  logic [6:0]         word0;
  logic [6:0]         word1;
  logic [1:0]         lane0;
  logic [1:0]         lane1;
  logic               fits_two;
  logic [AW-1:0]      row_base;
  csrb_plan_t         plan_nxt;

  assign row    = sprite_y + $signed({3'b000, row_index});
  assign row_ok = !row[10] && (32'(row[9:0]) < SCREEN_HEIGHT);
  assign neg    = sprite_x[10];
  assign x_ok   = (wide ? (sprite_x >= -11'sd15) : (sprite_x >= -11'sd7)) &&
                  (neg || (32'(sprite_x[9:0]) < SCREEN_WIDTH));

  assign neg_sh = 4'd0 - sprite_x[3:0];
  assign off    = wide ? sprite_x[3:0] : {1'b0, sprite_x[2:0]};
  assign back   = (wide ? 5'd16 : 5'd8) - {1'b0, off};
  assign mask16 = wide ? 16'hFFFF : 16'h00FF;
  assign bits16 = row_bits & mask16;

  assign v_first  = neg ? ((bits16 << neg_sh) & mask16) : (bits16 >> off);
  assign v_second = (bits16 << back) & mask16;

  assign word0 = neg ? 7'd0 : {1'b0, sprite_x[9:4]};
  assign word1 = {1'b0, sprite_x[9:4]} + (wide ? 7'd1 : {6'd0, sprite_x[3]});
  assign lane0 = wide ? LANE_BOTH : ((neg || !sprite_x[3]) ? LANE_HI : LANE_LO);
  assign lane1 = wide ? LANE_BOTH : (sprite_x[3] ? LANE_HI : LANE_LO);

  assign fits_two = wide ? (32'(sprite_x[9:0]) + 32'd16 < SCREEN_WIDTH)
                         : (32'(sprite_x[9:0]) + 32'd8 < SCREEN_WIDTH);

  assign row_base = AW'(32'(row[9:0]) * ROW_WORDS);

  always_comb begin
    plan_nxt.is_read = (kind == KIND_READ);
    plan_nxt.rd_ok   = (32'(read_address) < FB_WORDS);
    plan_nxt.drawn   = (kind == KIND_BLIT) && x_ok && row_ok;
    plan_nxt.done    = (kind == KIND_BLIT) && last_row;
    plan_nxt.erase   = erase;
    plan_nxt.u0_en   = plan_nxt.drawn;
    plan_nxt.u1_en   = plan_nxt.drawn && !neg && (off != 4'd0) && fits_two;
    plan_nxt.lane0   = lane0;
    plan_nxt.lane1   = lane1;
    plan_nxt.val0    = place(v_first, lane0);
    plan_nxt.val1    = place(v_second, lane1);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan_r  <= plan_nxt;
      addr0_r <= (kind == KIND_READ) ? AW'(read_address) : row_base + AW'(word0);
      addr1_r <= row_base + AW'(word1);
    end
  end

endmodule

[rtl/clipped_sprite_row_blitter_unit.sv]
// clipped_sprite_row_blitter_unit: top level with sequencer, output register and RAM.
// A beat passes RD0, then WR0 for a read or a drawn row, then RD1 and WR1 for a
// two-unit row, then DONE; the next beat is taken on the cycle the result loads,
// so no beat is taken before the last one is through. The pace is set by the single
// RAM port doing a read then a write per framebuffer unit, and an output stall holds it.
// After reset the RAM is cleared one word a cycle (16000 words at 640x400).
module clipped_sprite_row_blitter_unit
  import csrb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 400
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [10:0] in_sprite_x,
  input  logic signed [9:0]  in_sprite_y,
  input  logic [7:0]         in_row_index,
  input  logic [15:0]        in_row_bits,
  input  logic               in_wide,
  input  logic               in_erase,
  input  logic               in_last_row,
  input  logic [13:0]        in_read_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_read_data,
  output logic               out_row_drawn,
  output logic               out_sprite_done
);

  localparam int ROW_WORDS = (SCREEN_WIDTH + 15) / 16;
  localparam int FB_WORDS  = ROW_WORDS * SCREEN_HEIGHT;
  localparam int AW        = $clog2(FB_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD0, S_WR0, S_RD1, S_WR1, S_DONE
  } state_t;

  function automatic logic [15:0] merge(input logic [15:0] cur, input logic [15:0] v,
                                        input logic [1:0] lane, input logic clr);
    logic [15:0] m;
    m = clr ? (cur & v) : (cur | v);
    return {lane[1] ? m[15:8] : cur[15:8], lane[0] ? m[7:0] : cur[7:0]};
  endfunction

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic [15:0]   res_r;
  logic          out_valid_r;
  logic [15:0]   out_read_data_r;
  logic          out_row_drawn_r;
  logic          out_sprite_done_r;
  logic          out_free;
  logic          in_accept;

  csrb_plan_t    plan_r;
  logic [AW-1:0] addr0_r;
  logic [AW-1:0] addr1_r;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) || ((state_r == S_DONE) && out_free));
  assign in_accept = in_valid && !in_stall;

  csrb_plan #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW)
  ) u_plan (
    .clk          (clk),
    .load         (in_accept),
    .kind         (in_kind),
    .sprite_x     (in_sprite_x),
    .sprite_y     (in_sprite_y),
    .row_index    (in_row_index),
    .row_bits     (in_row_bits),
    .wide         (in_wide),
    .erase        (in_erase),
    .last_row     (in_last_row),
    .read_address (in_read_address),
    .plan_r       (plan_r),
    .addr0_r      (addr0_r),
    .addr1_r      (addr1_r)
  );

  csrb_fb_ram #(
    .DEPTH (FB_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr0_r;
    ram_wdata = merge(ram_rdata, plan_r.val0, plan_r.lane0, plan_r.erase);
    unique case (state_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = 16'h0000;
      end
      S_RD0: begin
        ram_en = plan_r.is_read ? plan_r.rd_ok : plan_r.u0_en;
      end
      S_WR0: begin
        ram_en = !plan_r.is_read;
        ram_we = !plan_r.is_read;
      end
      S_RD1: begin
        ram_en   = 1'b1;
        ram_addr = addr1_r;
      end
      S_WR1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = addr1_r;
        ram_wdata = merge(ram_rdata, plan_r.val1, plan_r.lane1, plan_r.erase);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(FB_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_accept) state_nxt = S_RD0;
      S_RD0:   state_nxt = (plan_r.is_read || plan_r.u0_en) ? S_WR0 : S_DONE;
      S_WR0:   state_nxt = (!plan_r.is_read && plan_r.u1_en) ? S_RD1 : S_DONE;
      S_RD1:   state_nxt = S_WR1;
      S_WR1:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = in_accept ? S_RD0 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == S_WR0) begin
        res_r <= ram_rdata;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r       <= 1'b1;
        out_read_data_r   <= (plan_r.is_read && plan_r.rd_ok) ? res_r : 16'h0000;
        out_row_drawn_r   <= plan_r.drawn;
        out_sprite_done_r <= plan_r.done;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_row_drawn   = out_row_drawn_r;
  assign out_sprite_done = out_sprite_done_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_RD0))
    else $error("accepted beat did not start a RAM pass");

  a_second_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |-> (plan_r.u1_en && !plan_r.is_read))
    else $error("second unit written without a planned second unit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

  a_blit_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_row_drawn_r && (out_read_data_r != 16'h0000)))
    else $error("drawn blit result carries read data");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !$past(in_accept))
    else $error("beat accepted during RAM clear");

endmodule

[test/csrb_scoreboard.sv]
`timescale 1ns / 100ps
// csrb_scoreboard: watches both channels of the sprite row blitter, keeps a shadow
// framebuffer, predicts each result and compares it. Depends on csrb_pkg.
module csrb_scoreboard
  import csrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic signed [10:0] in_sprite_x,
  input  logic signed [9:0]  in_sprite_y,
  input  logic [7:0]         in_row_index,
  input  logic [15:0]        in_row_bits,
  input  logic               in_wide,
  input  logic               in_erase,
  input  logic               in_last_row,
  input  logic [13:0]        in_read_address,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_read_data,
  input  logic               out_row_drawn,
  input  logic               out_sprite_done,
  output int                 fail_count,
  output int                 pending_results
);

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 400;
  localparam int ROW_BYTES     = 80;
  localparam int FB_BYTES      = ROW_BYTES * SCREEN_HEIGHT;

  typedef struct packed {
    logic [15:0] read_data;
    logic        row_drawn;
    logic        sprite_done;
  } blit_result_t;

  logic [7:0]   shadow_fb [0:FB_BYTES-1];
  blit_result_t results_due [$];
  int           mismatches;

  task automatic merge_unit(input int row_base, input int unit, input logic wide,
                            input logic erase, input logic [15:0] val);
    int          nbytes;
    int          addr;
    logic [15:0] cur;
    nbytes = wide ? 2 : 1;
    if (unit * nbytes + nbytes > ROW_BYTES) return;
    addr = row_base + unit * nbytes;
    if (addr + nbytes > FB_BYTES) return;
    if (wide) begin
      cur = {shadow_fb[addr], shadow_fb[addr+1]};
    end else begin
      cur = {8'h00, shadow_fb[addr]};
    end
    cur = erase ? (cur & val) : (cur | val);
    if (wide) begin
      shadow_fb[addr]   = cur[15:8];
      shadow_fb[addr+1] = cur[7:0];
    end else begin
      shadow_fb[addr] = cur[7:0];
    end
  endtask

  task automatic predict_beat();
    blit_result_t res;
    int           x;
    int           y;
    int           row;
    int           w;
    int           off;
    int           unit;
    int           word_addr;
    logic [15:0]  mask;
    logic [15:0]  bits;
    logic [31:0]  shifted;
    res = '0;
    if (in_kind == KIND_READ) begin
      word_addr = int'(in_read_address);
      if (word_addr * 2 + 1 < FB_BYTES)
        res.read_data = {shadow_fb[word_addr*2], shadow_fb[word_addr*2+1]};
    end else begin
      x    = in_sprite_x;
      y    = in_sprite_y;
      row  = y + int'(in_row_index);
      w    = in_wide ? 16 : 8;
      mask = in_wide ? 16'hFFFF : 16'h00FF;
      bits = in_row_bits & mask;
      res.sprite_done = in_last_row;
      if (!(x <= -w || x >= SCREEN_WIDTH || row < 0 || row >= SCREEN_HEIGHT)) begin
        res.row_drawn = 1'b1;
        if (x < 0) begin
          shifted = {16'h0000, bits} << (-x);
          merge_unit(row * ROW_BYTES, 0, in_wide, in_erase, shifted[15:0] & mask);
        end else begin
          unit = x / w;
          off  = x % w;
          merge_unit(row * ROW_BYTES, unit, in_wide, in_erase, bits >> off);
          if (x <= SCREEN_WIDTH - 1 - w && off != 0) begin
            shifted = {16'h0000, bits} << (w - off);
            merge_unit(row * ROW_BYTES, unit + 1, in_wide, in_erase, shifted[15:0] & mask);
          end
        end
      end
    end
    results_due.push_back(res);
  endtask

  task automatic check_beat();
    blit_result_t want;
    if (results_due.size() == 0) begin
      $error("result beat with no prediction waiting");
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    if (out_read_data !== want.read_data) begin
      $error("read_data expected %h actual %h", want.read_data, out_read_data);
      mismatches++;
    end
    if (out_row_drawn !== want.row_drawn) begin
      $error("row_drawn expected %b actual %b", want.row_drawn, out_row_drawn);
      mismatches++;
    end
    if (out_sprite_done !== want.sprite_done) begin
      $error("sprite_done expected %b actual %b", want.sprite_done, out_sprite_done);
      mismatches++;
    end
  endtask

  // retire the result first: a beat entering on the same edge is always younger
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) predict_beat();
    end
    fail_count      <= mismatches;
    pending_results <= results_due.size();
  end

endmodule

[test/tb_clipped_sprite_row_blitter_unit.sv]
`timescale 1ns / 100ps
// tb_clipped_sprite_row_blitter_unit: drives blit and read beats into the blitter
// under several idle and stall patterns; csrb_scoreboard checks the results.
module tb_clipped_sprite_row_blitter_unit
  import csrb_pkg::*;
();

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 400;
  localparam int WORDS_PER_ROW = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 155;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic signed [10:0] in_sprite_x;
  logic signed [9:0]  in_sprite_y;
  logic [7:0]         in_row_index;
  logic [15:0]        in_row_bits;
  logic               in_wide;
  logic               in_erase;
  logic               in_last_row;
  logic [13:0]        in_read_address;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_read_data;
  logic               out_row_drawn;
  logic               out_sprite_done;
  int                 fail_count;
  int                 pending_results;

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int beats_sent    = 0;
  int cycles        = 0;

  clipped_sprite_row_blitter_unit dut (.*);
  csrb_scoreboard scoreboard (.*);

  always #6 clk = ~clk;

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_clipped_sprite_row_blitter_unit failed");
    $finish;
  end

  // receiver: random stall, or a long hold when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic kind, input int x, input int y, input int ri,
                           input logic [15:0] bits, input logic wide, input logic erase,
                           input logic last, input int raddr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_sprite_x     <= x[10:0];
    in_sprite_y     <= y[9:0];
    in_row_index    <= ri[7:0];
    in_row_bits     <= bits;
    in_wide         <= wide;
    in_erase        <= erase;
    in_last_row     <= last;
    in_read_address <= raddr[13:0];
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_blit(input int x, input int y, input int ri, input logic [15:0] bits,
                           input logic wide, input logic erase, input logic last);
    send_beat(KIND_BLIT, x, y, ri, bits, wide, erase, last, $urandom_range(16383));
  endtask

  task automatic send_read(input int raddr);
    send_beat(KIND_READ, $urandom_range(2047), $urandom_range(1023), $urandom_range(255),
              16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), raddr);
  endtask

  task automatic send_sprite(input int x, input int y, input logic wide, input logic erase,
                             input int nrows);
    int rr;
    for (int r = 0; r < nrows; r++)
      send_blit(x, y, r, 16'($urandom), wide, erase, r == nrows - 1);
    // look back at one of the rows just drawn
    rr = y + $urandom_range(nrows - 1);
    if (rr >= 0 && rr < SCREEN_HEIGHT)
      send_read(rr * WORDS_PER_ROW + ((x > 0 && x < SCREEN_WIDTH) ? x / 16 : 0)
                + $urandom_range(1));
  endtask

  task automatic run_random(input int nbeats);
    int   last_beat;
    int   roll;
    int   x;
    int   y;
    int   w;
    int   px;
    int   py;
    logic wide;
    logic pwide;
    logic have_prev;
    last_beat = beats_sent + nbeats;
    have_prev = 1'b0;
    px = 0;
    py = 0;
    pwide = 1'b0;
    while (beats_sent < last_beat) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        if (have_prev && $urandom_range(99) < 40) begin
          x = px;
          y = py;
          wide = pwide;
        end else begin
          wide = 1'($urandom_range(1));
          w = wide ? 16 : 8;
          case ($urandom_range(5))
            0: x = -1 - $urandom_range(w - 2);
            1: x = SCREEN_WIDTH - 1 - $urandom_range(2 * w);
            2, 3: x = $urandom_range(SCREEN_WIDTH - 1);
            4: x = $urandom_range(1) ? -w - $urandom_range(8)
                                     : SCREEN_WIDTH + $urandom_range(383);
            default: x = $urandom_range(SCREEN_WIDTH - 1) & ~(w - 1);
          endcase
          case ($urandom_range(3))
            0: y = -1 - $urandom_range(7);
            1: y = SCREEN_HEIGHT - 8 + $urandom_range(7);
            default: y = $urandom_range(SCREEN_HEIGHT - 9);
          endcase
        end
        px = x;
        py = y;
        pwide = wide;
        have_prev = 1'b1;
        send_sprite(x, y, wide, $urandom_range(99) < 30, $urandom_range(1, 8));
      end else if (roll < 85) begin
        send_blit($urandom_range(2047), $urandom_range(1023), $urandom_range(255),
                  16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (roll < 93) begin
        send_read($urandom_range(16383));
      end else begin
        send_read($urandom_range(SCREEN_HEIGHT * WORDS_PER_ROW - 1));
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_BLIT;
    in_sprite_x     <= '0;
    in_sprite_y     <= '0;
    in_row_index    <= '0;
    in_row_bits     <= '0;
    in_wide         <= 1'b0;
    in_erase        <= 1'b0;
    in_last_row     <= 1'b0;
    in_read_address <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_read(0);
    send_read(16383);
    send_blit(0, 0, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(-16, 1, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(-15, 1, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(-8, 2, 0, 16'h00FF, 1'b0, 1'b0, 1'b0);
    send_blit(-1, 2, 0, 16'hFF81, 1'b0, 1'b0, 1'b1);
    send_blit(639, 3, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(632, 4, 0, 16'h00A5, 1'b0, 1'b0, 1'b0);
    send_blit(631, 5, 0, 16'h00FF, 1'b0, 1'b0, 1'b0);
    send_blit(623, 6, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(640, 7, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(1023, 7, 0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_blit(-1024, 7, 0, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    send_blit(10, -1, 0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_blit(20, -200, 200, 16'hC3C3, 1'b1, 1'b0, 1'b0);
    send_blit(624, 399, 0, 16'h8001, 1'b1, 1'b0, 1'b0);
    send_blit(624, 399, 1, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    send_blit(100, 511, 255, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_blit(100, -512, 255, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_blit(4, 0, 0, 16'h0FF0, 1'b1, 1'b1, 1'b1);
    send_read(0);
    send_read(1);
    send_read(SCREEN_HEIGHT * WORDS_PER_ROW - 1);
    send_read(SCREEN_HEIGHT * WORDS_PER_ROW);

    // fill the block while the receiver holds off
    hold_requests++;
    run_random(PHASE_BEATS);
    tx_idle_pct = 83;
    run_random(PHASE_BEATS);
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    run_random(PHASE_BEATS);
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    run_random(PHASE_BEATS);

    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_clipped_sprite_row_blitter_unit passed");
    end else begin
      $display("tb_clipped_sprite_row_blitter_unit failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/csrb_pkg.sv
rtl/csrb_fb_ram.sv
rtl/csrb_plan.sv
rtl/clipped_sprite_row_blitter_unit.sv
test/csrb_scoreboard.sv
test/tb_clipped_sprite_row_blitter_unit.sv
